>>> rtl/assert_macros.svh
// Assertion macros used by the checker file hit_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define HIT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hash intern table assertion failed");

// Check that a condition never holds outside reset.
`define HIT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hash intern table forbidden condition");

`endif

>>> rtl/hit_pkg.sv
// Types and constants of the hash intern table.
// No dependencies.
package hit_pkg;

    localparam int KEY_W = 32;
    localparam int LEN_W = 16;
    localparam int BLK_W = 16;
    localparam int OFF_W = 16;

    localparam logic [LEN_W-1:0] LEN_MAX = 16'd65534;
    localparam logic [LEN_W-1:0] BLOCK_SIZE_RESET = 16'd4096;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic [OFF_W-1:0] off;
    } place_t;

    typedef struct packed {
        logic             occ;
        logic             lt;
        logic [KEY_W-1:0] key;
        place_t           place;
    } cell_link_t;

endpackage

>>> rtl/hash_intern_table_unit.sv
// Hash intern table: sorted row of key cells plus a text block allocator.
// The result item is registered when the update pass (S_UPD) fires, after a compare pass (S_CMP);
// a new item is taken only in S_IDLE or as the update pass fires, and a stalled output holds S_UPD.
// Reset clears the entry count and allocator and sets block_size to 4096; no clearing pass.
// Depends on hit_pkg, hit_cell, hit_alloc.
module hash_intern_table_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [hit_pkg::LEN_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [hit_pkg::KEY_W-1:0] hash,
    input  logic [hit_pkg::LEN_W-1:0] string_length,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [hit_pkg::BLK_W-1:0] handle_block,
    output logic [hit_pkg::OFF_W-1:0] handle_offset,
    output logic                      table_full
);
    import hit_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [KEY_W-1:0] hash_reg;
    logic [LEN_W-1:0] len_reg;
    logic             out_valid_reg;
    logic             found_reg;
    logic [BLK_W-1:0] block_reg;
    logic [OFF_W-1:0] offset_reg;
    logic             full_reg;

    cell_link_t       links [TABLE_DEPTH+1];
    logic             hits [TABLE_DEPTH];
    place_t           hit_places [TABLE_DEPTH];
    place_t           new_place;
    place_t           sel_place;
    logic             any_hit;
    logic             is_full;
    logic             out_free;
    logic             accept;
    logic             upd_fire;
    logic             insert;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !(state_reg == S_IDLE || (state_reg == S_UPD && out_free));
    assign accept   = in_valid && !in_stall;
    assign upd_fire = state_reg == S_UPD && out_free;
    assign is_full  = count_reg == CNT_W'(TABLE_DEPTH);
    assign insert   = upd_fire && !any_hit && !is_full;

    always_comb
    begin
        any_hit   = 1'b0;
        sel_place = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            any_hit   = any_hit | hits[i];
            sel_place = sel_place | hit_places[i];
        end
    end

    assign links[0].occ   = 1'b1;
    assign links[0].lt    = 1'b1;
    assign links[0].key   = '0;
    assign links[0].place = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        hit_cell #(
            .CNT_W(CNT_W),
            .IDX  (g)
        ) u_cell (
            .clk      (clk),
            .cmp_en   (state_reg == S_CMP),
            .ins_en   (insert),
            .count    (count_reg),
            .cmp_key  (hash_reg),
            .new_place(new_place),
            .prev     (links[g]),
            .link     (links[g+1]),
            .hit      (hits[g]),
            .hit_place(hit_places[g])
        );
    end

    hit_alloc u_alloc (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data),
        .alloc_en (insert),
        .len      (len_reg),
        .place    (new_place)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hash_reg <= hash;
            len_reg  <= string_length;
        end
        if (upd_fire)
        begin
            found_reg <= any_hit;
            full_reg  <= !any_hit && is_full;
            if (any_hit)
            begin
                block_reg  <= sel_place.blk;
                offset_reg <= sel_place.off;
            end
            else if (is_full)
            begin
                block_reg  <= '0;
                offset_reg <= '0;
            end
            else
            begin
                block_reg  <= new_place.blk;
                offset_reg <= new_place.off;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (out_free)
                    begin
                        state_reg <= accept ? S_CMP : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (upd_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign handle_block  = block_reg;
    assign handle_offset = offset_reg;
    assign table_full    = full_reg;

endmodule

>>> rtl/hit_cell.sv
// One cell of the sorted key row: holds a key and its place, compares, shifts.
// Depends on hit_pkg.
module hit_cell #(
    parameter int CNT_W = 9,
    parameter int IDX = 0
) (
    input  logic                     clk,
    input  logic                     cmp_en,
    input  logic                     ins_en,
    input  logic [CNT_W-1:0]         count,
    input  logic [hit_pkg::KEY_W-1:0] cmp_key,
    input  hit_pkg::place_t          new_place,
    input  hit_pkg::cell_link_t      prev,
    output hit_pkg::cell_link_t      link,
    output logic                     hit,
    output hit_pkg::place_t          hit_place
);
    import hit_pkg::*;

    logic [KEY_W-1:0] key_reg;
    place_t           place_reg;
    logic             lt_reg;
    logic             eq_reg;
    logic             occ;

    assign occ = CNT_W'(IDX) < count;

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            lt_reg <= occ && (key_reg < cmp_key);
            eq_reg <= occ && (key_reg == cmp_key);
        end
        if (ins_en)
        begin
            if (prev.lt && !lt_reg)
            begin
                key_reg   <= cmp_key;
                place_reg <= new_place;
            end
            else if (prev.occ && !prev.lt)
            begin
                key_reg   <= prev.key;
                place_reg <= prev.place;
            end
        end
    end

    assign link.occ   = occ;
    assign link.lt    = lt_reg;
    assign link.key   = key_reg;
    assign link.place = place_reg;

    assign hit       = eq_reg;
    assign hit_place = eq_reg ? place_reg : '0;

endmodule

>>> rtl/hit_alloc.sv
// Bump allocator for text blocks and the block size register.
// Depends on hit_pkg.
module hit_alloc (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [hit_pkg::LEN_W-1:0] cfg_data,
    input  logic                      alloc_en,
    input  logic [hit_pkg::LEN_W-1:0] len,
    output hit_pkg::place_t           place
);
    import hit_pkg::*;

    logic [LEN_W-1:0] block_size_reg;
    logic [BLK_W-1:0] cur_block_reg;
    logic [OFF_W-1:0] used_reg;
    logic             open_reg;

    logic [LEN_W-1:0] len_c;
    logic [LEN_W:0]   need;
    logic [LEN_W:0]   sum;
    logic             over;
    logic [OFF_W-1:0] base;
    logic [OFF_W-1:0] used_next;

    always_comb
    begin
        len_c = (len > LEN_MAX) ? LEN_MAX : len;
        need  = {1'b0, len_c} + (LEN_W+1)'(1);
        sum   = {1'b0, used_reg} + need;
        over  = sum > {1'b0, block_size_reg};
        if (!open_reg)
        begin
            place.blk = '0;
            base      = '0;
        end
        else if (over)
        begin
            place.blk = cur_block_reg + BLK_W'(1);
            base      = '0;
        end
        else
        begin
            place.blk = cur_block_reg;
            base      = used_reg;
        end
        place.off = base;
        used_next = base + need[OFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RESET;
            cur_block_reg  <= '0;
            used_reg       <= '0;
            open_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                block_size_reg <= cfg_data;
            end
            if (alloc_en)
            begin
                cur_block_reg <= place.blk;
                used_reg      <= used_next;
                open_reg      <= 1'b1;
            end
        end
    end

endmodule

>>> rtl/hit_checker.sv
// Port-level checks of the hash intern table, bound to the top level.
// Depends on assert_macros.svh and hash_intern_table_unit.
`include "assert_macros.svh"

module hit_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic [15:0] handle_block,
    input logic [15:0] handle_offset,
    input logic        table_full
);

    `HIT_NEVER(a_found_and_full, clk, rst_n, out_valid && found && table_full)

    `HIT_ASSERT(a_full_zero_handle, clk, rst_n,
        out_valid && table_full |-> handle_block == 16'd0 && handle_offset == 16'd0)

    `HIT_ASSERT(a_accept_then_busy, clk, rst_n, in_valid && !in_stall |=> in_stall)

    `HIT_ASSERT(a_out_hold, clk, rst_n,
        out_valid && out_stall |=> out_valid && $stable(found) &&
        $stable(handle_block) && $stable(handle_offset))

endmodule

bind hash_intern_table_unit hit_port_checker u_hit_checker (.*);
